// File: hw/rtl/tgm_pkg.sv
package tgm_pkg;

	localparam int unsigned TapTime   = 250;
	localparam int unsigned TapDistSq = 25600;
	localparam int unsigned ClickTime = 50;
	localparam int unsigned MaxX      = 15360;
	localparam int unsigned MaxY      = 8704;

	typedef enum logic [1:0] {
		KIND_DOWN   = 2'd0,
		KIND_UP     = 2'd1,
		KIND_MOTION = 2'd2,
		KIND_TICK   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_INDIRECT = 3'd0,
		REG_SPEED    = 3'd1,
		REG_ORG_X    = 3'd2,
		REG_ORG_Y    = 3'd3,
		REG_INV_X    = 3'd4,
		REG_INV_Y    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		kind_t              kind;
		logic               port;
		logic [7:0]         touch_id;
		logic [31:0]        time_ms;
		logic [13:0]        x_pos;
		logic [13:0]        y_pos;
		logic signed [14:0] dx;
		logic signed [14:0] dy;
	} evt_t;

	typedef struct packed {
		logic signed [15:0] pointer_x;
		logic signed [15:0] pointer_y;
		logic               button_left;
		logic               button_right;
	} res_t;

	typedef struct packed {
		logic               indirect_front;
		logic [15:0]        pointer_speed;
		logic signed [13:0] org_x;
		logic signed [13:0] org_y;
		logic [15:0]        inv_scale_x;
		logic [15:0]        inv_scale_y;
	} cfg_t;

	function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
		if (v > 48'sd32767) return 16'sh7fff;
		if (v < -48'sd32768) return -16'sh8000;
		return v[15:0];
	endfunction

endpackage

// File: hw/rtl/tgm_front.sv
module tgm_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tgm_pkg::evt_t  in_evt,
	output logic           q_valid,
	input  logic           q_ready,
	output tgm_pkg::evt_t  q_evt
);
	import tgm_pkg::*;

	localparam int Depth = 2;

	evt_t        mem_q [Depth];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	evt_t        cl;

	always_comb begin
		cl = in_evt;
		if (in_evt.x_pos > 14'(MaxX)) cl.x_pos = 14'(MaxX);
		if (in_evt.y_pos > 14'(MaxY)) cl.y_pos = 14'(MaxY);
	end

	assign in_ready = (cnt_q != 2'(Depth));
	assign q_valid  = (cnt_q != 2'd0);
	assign q_evt    = mem_q[rp_q];

	wire push = in_valid && in_ready;
	wire pop  = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= cl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

`ifndef SYNTHESIS
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(Depth))
		else $error("queue count overflow");
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'(Depth)) |-> wp_q == rp_q)
		else $error("queue pointers inconsistent");
	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("queue push lost");
`endif
endmodule

// File: hw/rtl/tgm_back.sv
module tgm_back #(
	parameter int NUM_PANELS   = 2,
	parameter int FINGER_SLOTS = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tgm_pkg::cfg_t cfg,
	input  logic          q_valid,
	output logic          q_ready,
	input  tgm_pkg::evt_t q_evt,
	output logic          res_valid,
	input  logic          res_ready,
	output tgm_pkg::res_t res
);
	import tgm_pkg::*;

	localparam int NS = NUM_PANELS * FINGER_SLOTS;
	localparam int PW = (NUM_PANELS > 1) ? $clog2(NUM_PANELS) : 1;
	localparam int CW = $clog2(FINGER_SLOTS + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DEC  = 5'b00010,
		ST_MUL1 = 5'b00100,
		ST_MUL2 = 5'b01000,
		ST_OUT  = 5'b10000
	} st_t;

	st_t st_q;
	evt_t e_q;

	logic        sv_q [NS];
	logic [7:0]  sid_q [NS];
	logic [31:0] st_tm_q [NS];
	logic [13:0] sx_q [NS];
	logic [13:0] sy_q [NS];
	logic [1:0]  drag_q [NUM_PANELS];
	logic [31:0] click_q [NUM_PANELS*2];
	logic signed [8:0]  frac_x_q, frac_y_q;
	logic signed [15:0] px_q, py_q;
	logic [1:0]  btn_q;

	logic        abs_q, upd_q;
	logic signed [31:0] prod_x_q, prod_y_q;
	logic signed [47:0] mul_x_q, mul_y_q;

	wire [PW-1:0] pq = PW'(e_q.port);
	wire in_rng_q = 32'(e_q.port) < 32'(NUM_PANELS);

	assign q_ready   = (st_q == ST_IDLE);
	assign res_valid = (st_q == ST_OUT);
	assign res.pointer_x = px_q;
	assign res.pointer_y = py_q;
	assign res.button_left  = btn_q[0];
	assign res.button_right = btn_q[1];

	// decode-stage combinational helpers
	logic [CW-1:0] n_cnt, lng;
	logic          upd;

	always_comb begin
		n_cnt = '0; lng = '0; upd = 1'b1;
		for (int i = 0; i < FINGER_SLOTS; i++) begin
			if (sv_q[32'(pq)*FINGER_SLOTS+i]) begin
				n_cnt = n_cnt + CW'(1);
				if (e_q.time_ms - st_tm_q[32'(pq)*FINGER_SLOTS+i] > TapTime)
					lng = lng + CW'(1);
			end
		end
		for (int i = 0; i < FINGER_SLOTS; i++) begin
			if (sv_q[32'(pq)*FINGER_SLOTS+i] && sid_q[32'(pq)*FINGER_SLOTS+i] == e_q.touch_id)
				for (int j = 0; j < FINGER_SLOTS; j++)
					if (j != i && sv_q[32'(pq)*FINGER_SLOTS+j] &&
						st_tm_q[32'(pq)*FINGER_SLOTS+j] < st_tm_q[32'(pq)*FINGER_SLOTS+i])
						upd = 1'b0;
		end
		if (n_cnt <= CW'(1)) upd = 1'b1;
	end

	// absolute mapping / relative products
	logic signed [18:0] rx, ry;
	logic signed [32:0] sx_p, sy_p;
	always_comb begin
		rx = $signed({5'b0, e_q.x_pos}) - ($signed({{5{cfg.org_x[13]}}, cfg.org_x}) <<< 4);
		ry = $signed({5'b0, e_q.y_pos}) - ($signed({{5{cfg.org_y[13]}}, cfg.org_y}) <<< 4);
		sx_p = $signed({{18{e_q.dx[14]}}, e_q.dx}) * $signed({17'b0, cfg.pointer_speed});
		sy_p = $signed({{18{e_q.dy[14]}}, e_q.dy}) * $signed({17'b0, cfg.pointer_speed});
	end

	function automatic logic signed [47:0] tdiv16(input logic signed [47:0] v);
		logic signed [47:0] a;
		a = v + ((v < 0) ? 48'sd65535 : 48'sd0);
		return a >>> 16;
	endfunction

	logic signed [47:0] mx, my;
	always_comb begin
		if (abs_q) begin
			mx = 48'(rx) * $signed({32'b0, cfg.inv_scale_x});
			my = 48'(ry) * $signed({32'b0, cfg.inv_scale_y});
		end else begin
			mx = 48'(prod_x_q) * $signed({32'b0, cfg.inv_scale_x});
			my = 48'(prod_y_q) * $signed({32'b0, cfg.inv_scale_y});
		end
	end

	logic signed [47:0] ax, ay, accx, accy, wx, wy;
	always_comb begin
		ax = tdiv16(mul_x_q);
		ay = tdiv16(mul_y_q);
		accx = 48'(frac_x_q) + ax;
		accy = 48'(frac_y_q) + ay;
		wx = (accx + ((accx < 0) ? 48'sd255 : 48'sd0)) >>> 8;
		wy = (accy + ((accy < 0) ? 48'sd255 : 48'sd0)) >>> 8;
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) e_q <= q_evt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			for (int i = 0; i < NS; i++) begin
				sv_q[i] <= 1'b0; sid_q[i] <= '0; st_tm_q[i] <= '0; sx_q[i] <= '0; sy_q[i] <= '0;
			end
			for (int i = 0; i < NUM_PANELS; i++) drag_q[i] <= '0;
			for (int i = 0; i < NUM_PANELS*2; i++) click_q[i] <= '0;
			frac_x_q <= '0; frac_y_q <= '0; px_q <= '0; py_q <= '0; btn_q <= '0;
			abs_q <= 1'b0; upd_q <= 1'b0; prod_x_q <= '0; prod_y_q <= '0;
			mul_x_q <= '0; mul_y_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: if (q_valid) st_q <= ST_DEC;
				ST_DEC: begin : dec
					logic go;
					go = 1'b0;
					abs_q <= (e_q.port == 1'b0) && !cfg.indirect_front;
					prod_x_q <= sx_p[31:0];
					prod_y_q <= sy_p[31:0];
					if (in_rng_q) begin
						unique case (e_q.kind)
							KIND_DOWN: begin : dn
								logic done;
								logic fr [FINGER_SLOTS];
								done = 1'b0;
								for (int i = 0; i < FINGER_SLOTS; i++)
									fr[i] = !sv_q[32'(pq)*FINGER_SLOTS+i] ||
										sid_q[32'(pq)*FINGER_SLOTS+i] == e_q.touch_id;
								for (int i = 0; i < FINGER_SLOTS; i++) begin
									if (fr[i] && !done) begin
										done = 1'b1;
										sv_q[32'(pq)*FINGER_SLOTS+i]    <= 1'b1;
										sid_q[32'(pq)*FINGER_SLOTS+i]   <= e_q.touch_id;
										st_tm_q[32'(pq)*FINGER_SLOTS+i] <= e_q.time_ms;
										sx_q[32'(pq)*FINGER_SLOTS+i]    <= e_q.x_pos;
										sy_q[32'(pq)*FINGER_SLOTS+i]    <= e_q.y_pos;
									end else if (fr[i]) begin
										sv_q[32'(pq)*FINGER_SLOTS+i] <= 1'b0;
									end
								end
							end
							KIND_UP: begin : up
								logic [1:0] b;
								logic [1:0] dm;
								logic       tapabs;
								logic signed [14:0] ux, uy;
								b = btn_q; dm = drag_q[pq]; tapabs = 1'b0;
								for (int i = 0; i < FINGER_SLOTS; i++) begin
									if (sv_q[32'(pq)*FINGER_SLOTS+i] &&
										sid_q[32'(pq)*FINGER_SLOTS+i] == e_q.touch_id) begin
										sv_q[32'(pq)*FINGER_SLOTS+i] <= 1'b0;
										ux = $signed({1'b0, e_q.x_pos}) - $signed({1'b0, sx_q[32'(pq)*FINGER_SLOTS+i]});
										uy = $signed({1'b0, e_q.y_pos}) - $signed({1'b0, sy_q[32'(pq)*FINGER_SLOTS+i]});
										if (dm == 2'd0) begin
											if (e_q.time_ms - st_tm_q[32'(pq)*FINGER_SLOTS+i] <= TapTime &&
												31'(ux*ux) + 31'(uy*uy) < 31'(TapDistSq)) begin
												if (n_cnt == CW'(2)) begin
													click_q[32'(pq)*2+1] <= e_q.time_ms; b[1] = 1'b1;
												end else if (n_cnt == CW'(1)) begin
													tapabs = 1'b1;
													click_q[32'(pq)*2] <= e_q.time_ms; b[0] = 1'b1;
												end
											end
										end else if (n_cnt == CW'(1)) begin
											b = b & ((dm == 2'd2) ? 2'b01 : 2'b10);
											dm = 2'd0;
										end
									end
								end
								btn_q <= b; drag_q[pq] <= dm;
								if (tapabs && (e_q.port == 1'b0) && !cfg.indirect_front)
									go = 1'b1;
							end
							KIND_MOTION: begin
								if (n_cnt >= CW'(1)) begin
									if (n_cnt >= CW'(2) && drag_q[pq] == 2'd0) begin
										if (lng == CW'(2)) begin
											drag_q[pq] <= 2'd1; btn_q[0] <= 1'b1;
										end else if (lng > CW'(2)) begin
											drag_q[pq] <= 2'd2; btn_q[1] <= 1'b1;
										end
									end
									if (upd) go = 1'b1;
								end
							end
							KIND_TICK: begin
								for (int i = 0; i < 2; i++)
									if (click_q[32'(pq)*2+i] != 0 &&
										e_q.time_ms - click_q[32'(pq)*2+i] >= ClickTime) begin
										btn_q[i] <= 1'b0;
										click_q[32'(pq)*2+i] <= '0;
									end
							end
							default: ;
						endcase
					end
					upd_q <= go;
					st_q <= go ? ST_MUL1 : ST_OUT;
				end
				ST_MUL1: begin
					mul_x_q <= mx;
					mul_y_q <= my;
					st_q <= ST_MUL2;
				end
				ST_MUL2: begin
					if (abs_q) begin
						px_q <= sat16(ax);
						py_q <= sat16(ay);
					end else begin
						px_q <= sat16(48'(px_q) + wx);
						py_q <= sat16(48'(py_q) + wy);
						frac_x_q <= 9'(accx - (wx <<< 8));
						frac_y_q <= 9'(accy - (wy <<< 8));
					end
					st_q <= ST_OUT;
				end
				ST_OUT: if (res_ready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_mul: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_MUL2 |-> upd_q)
		else $error("pointer update without request");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_OUT && !res_ready |=> st_q == ST_OUT && $stable(px_q) && $stable(btn_q))
		else $error("result changed while stalled");
	a_frac: assert property (@(posedge clk) disable iff (!arst_n)
		frac_x_q != -9'sd256 && frac_y_q != -9'sd256)
		else $error("fraction out of range");
`endif
endmodule

// File: hw/rtl/touch_gesture_to_mouse.sv
// Touch gesture to mouse translator.
// Slave stream s_axis: one finger event per item (down, up, motion, tick),
// tagged with panel number and finger id. Master stream m_axis: one item per
// event, the pointer position and button state after that event.
// A two-entry queue sits in front of the gesture engine so event intake
// continues while the engine works or the receiver stalls.
// Items that leave the pointer alone go from the decode state straight to
// the output state; when the pointer moves, the product register stage and
// then the scale and saturate stage come between. The engine handles one
// event at a time and takes the next only after its result is accepted.
// While m_axis_tready is low the result holds and the engine waits; the queue
// fills and then s_axis_tready drops.
// Reset clears all finger slots, drag modes, pending clicks, pointer and
// buttons, and loads the register defaults (speed 1.0, scales 1/16, offsets 0).
// Config writes via cfg_we/cfg_addr/cfg_wdata take effect on the next cycle,
// and must only happen while idle.
module touch_gesture_to_mouse #(
	parameter int NUM_PANELS   = 2,
	parameter int FINGER_SLOTS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// kind[1:0], port[2], touch_id[10:3], time_ms[42:11], x_pos[56:43],
	// y_pos[70:57], dx[85:71], dy[100:86], zero fill to 104
	input  logic [103:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pointer_x[15:0], pointer_y[31:16], button_left[32], button_right[33]
	output logic [39:0] m_axis_tdata
);
	import tgm_pkg::*;

	cfg_t cfg_q;
	evt_t in_evt, q_evt;
	logic q_valid, q_ready;
	res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.indirect_front <= 1'b0;
			cfg_q.pointer_speed  <= 16'd256;
			cfg_q.org_x          <= '0;
			cfg_q.org_y          <= '0;
			cfg_q.inv_scale_x    <= 16'd4096;
			cfg_q.inv_scale_y    <= 16'd4096;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_INDIRECT: cfg_q.indirect_front <= cfg_wdata[0];
				REG_SPEED:    cfg_q.pointer_speed  <= cfg_wdata;
				REG_ORG_X:    cfg_q.org_x          <= cfg_wdata[13:0];
				REG_ORG_Y:    cfg_q.org_y          <= cfg_wdata[13:0];
				REG_INV_X:    cfg_q.inv_scale_x    <= cfg_wdata;
				REG_INV_Y:    cfg_q.inv_scale_y    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_evt.kind      = kind_t'(s_axis_tdata[1:0]);
	assign in_evt.port      = s_axis_tdata[2];
	assign in_evt.touch_id  = s_axis_tdata[10:3];
	assign in_evt.time_ms   = s_axis_tdata[42:11];
	assign in_evt.x_pos     = s_axis_tdata[56:43];
	assign in_evt.y_pos     = s_axis_tdata[70:57];
	assign in_evt.dx        = s_axis_tdata[85:71];
	assign in_evt.dy        = s_axis_tdata[100:86];

	tgm_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_evt,
		.q_valid, .q_ready, .q_evt
	);

	tgm_back #(.NUM_PANELS(NUM_PANELS), .FINGER_SLOTS(FINGER_SLOTS)) u_back (
		.clk, .arst_n, .cfg(cfg_q),
		.q_valid, .q_ready, .q_evt,
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
	);

	assign m_axis_tdata = {6'b0, res.button_right, res.button_left, res.pointer_y, res.pointer_x};

	logic unused_in;
	assign unused_in = ^s_axis_tdata[103:101];
endmodule

// File: tb/touch_gesture_to_mouse_test.sv
`timescale 1ns / 1ps

module touch_gesture_to_mouse_test;
	import tgm_pkg::*;

	localparam int NPAN = 2;
	localparam int NSLOT = 3;
	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_addr;
	logic [15:0] cfg_wdata;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [103:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [39:0] m_axis_tdata;

	touch_gesture_to_mouse u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// mirror state
	logic cf_indirect;
	longint cf_speed, cf_offx, cf_offy, cf_invx, cf_invy;
	bit sl_valid[NPAN*NSLOT];
	logic [7:0] sl_id[NPAN*NSLOT];
	logic [31:0] sl_time[NPAN*NSLOT];
	longint sl_x[NPAN*NSLOT], sl_y[NPAN*NSLOT];
	int drag[NPAN];
	logic [31:0] click_t[NPAN*2];
	longint fr_x, fr_y, ptr_x, ptr_y;
	logic [1:0] btn;

	res_t pending_res[$];
	int errors;
	int n_results;
	int idle_cycles;
	bit rx_hold;
	bit no_idle;
	logic [31:0] now_ms;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint clip16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic longint map_abs(longint pos, longint off, longint inv);
		return clip16(((pos - 16 * off) * inv) / 65536);
	endfunction

	task automatic move_rel(input longint d_in, input longint inv, inout longint fr,
			inout longint ptr);
		longint d, acc, whole;
		d = (d_in * cf_speed * inv) / 65536;
		acc = fr + d;
		whole = acc / 256;
		ptr = clip16(ptr + whole);
		fr = acc - whole * 256;
	endtask

	function automatic int fingers_down(int base);
		int n;
		n = 0;
		for (int i = 0; i < NSLOT; i++) if (sl_valid[base + i]) n++;
		return n;
	endfunction

	task automatic predict_gesture(input evt_t e);
		int base, n, lng;
		longint x, y, ex, ey;
		bit absm, upd;
		res_t r;
		x = e.x_pos > MaxX ? MaxX : e.x_pos;
		y = e.y_pos > MaxY ? MaxY : e.y_pos;
		absm = (e.port == 0) && !cf_indirect;
		base = e.port * NSLOT;
		case (e.kind)
			KIND_DOWN: begin
				for (int i = 0; i < NSLOT; i++)
					if (sl_valid[base+i] && sl_id[base+i] == e.touch_id)
						sl_valid[base+i] = 0;
				for (int i = 0; i < NSLOT; i++) begin
					if (!sl_valid[base+i]) begin
						sl_valid[base+i] = 1; sl_id[base+i] = e.touch_id;
						sl_time[base+i] = e.time_ms; sl_x[base+i] = x; sl_y[base+i] = y;
						break;
					end
				end
			end
			KIND_UP: begin
				n = fingers_down(base);
				for (int i = 0; i < NSLOT; i++) begin
					if (!sl_valid[base+i] || sl_id[base+i] != e.touch_id) continue;
					sl_valid[base+i] = 0;
					if (drag[e.port] == 0) begin
						ex = x - sl_x[base+i];
						ey = y - sl_y[base+i];
						if (32'(e.time_ms - sl_time[base+i]) <= TapTime &&
								ex*ex + ey*ey < TapDistSq) begin
							if (n == 2) begin
								click_t[e.port*2+1] = e.time_ms; btn[1] = 1;
							end else if (n == 1) begin
								if (absm) begin
									ptr_x = map_abs(x, cf_offx, cf_invx);
									ptr_y = map_abs(y, cf_offy, cf_invy);
								end
								click_t[e.port*2] = e.time_ms; btn[0] = 1;
							end
						end
					end else if (n == 1) begin
						btn = btn & ((drag[e.port] == 2) ? 2'b01 : 2'b10);
						drag[e.port] = 0;
					end
				end
			end
			KIND_MOTION: begin
				n = fingers_down(base);
				if (n >= 1) begin
					upd = 1;
					if (n >= 2 && drag[e.port] == 0) begin
						lng = 0;
						for (int i = 0; i < NSLOT; i++)
							if (sl_valid[base+i] && 32'(e.time_ms - sl_time[base+i]) > TapTime)
								lng++;
						if (lng == 2) begin
							drag[e.port] = 1; btn[0] = 1;
						end else if (lng > 2) begin
							drag[e.port] = 2; btn[1] = 1;
						end
					end
					if (n > 1)
						for (int i = 0; i < NSLOT; i++) begin
							if (!sl_valid[base+i] || sl_id[base+i] != e.touch_id) continue;
							for (int j = 0; j < NSLOT; j++)
								if (j != i && sl_valid[base+j] && sl_time[base+j] < sl_time[base+i])
									upd = 0;
						end
					if (upd) begin
						if (absm) begin
							ptr_x = map_abs(x, cf_offx, cf_invx);
							ptr_y = map_abs(y, cf_offy, cf_invy);
						end else begin
							move_rel(longint'(e.dx), cf_invx, fr_x, ptr_x);
							move_rel(longint'(e.dy), cf_invy, fr_y, ptr_y);
						end
					end
				end
			end
			default: begin
				for (int i = 0; i < 2; i++)
					if (click_t[e.port*2+i] != 0 &&
							32'(e.time_ms - click_t[e.port*2+i]) >= ClickTime) begin
						btn[i] = 0; click_t[e.port*2+i] = 0;
					end
			end
		endcase
		r.pointer_x = ptr_x[15:0];
		r.pointer_y = ptr_y[15:0];
		r.button_left = btn[0];
		r.button_right = btn[1];
		pending_res.push_back(r);
	endtask

	task automatic mirror_reset();
		cf_indirect = 0; cf_speed = 256; cf_offx = 0; cf_offy = 0;
		cf_invx = 4096; cf_invy = 4096;
		for (int i = 0; i < NPAN*NSLOT; i++) begin
			sl_valid[i] = 0; sl_id[i] = 0; sl_time[i] = 0; sl_x[i] = 0; sl_y[i] = 0;
		end
		for (int i = 0; i < NPAN; i++) drag[i] = 0;
		for (int i = 0; i < NPAN*2; i++) click_t[i] = 0;
		fr_x = 0; fr_y = 0; ptr_x = 0; ptr_y = 0; btn = 0;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		wait_drained();
		cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_INDIRECT: cf_indirect = val[0];
			REG_SPEED: cf_speed = val;
			REG_ORG_X: cf_offx = longint'($signed(val[13:0]));
			REG_ORG_Y: cf_offy = longint'($signed(val[13:0]));
			REG_INV_X: cf_invx = val;
			default: cf_invy = val;
		endcase
	endtask

	task automatic send_event(input kind_t k, input logic p, input logic [7:0] id,
			input logic [31:0] t, input logic [13:0] x, input logic [13:0] y,
			input logic signed [14:0] ddx, input logic signed [14:0] ddy);
		evt_t e;
		e.kind = k; e.port = p; e.touch_id = id; e.time_ms = t;
		e.x_pos = x; e.y_pos = y; e.dx = ddx; e.dy = ddy;
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {3'b0, e.dy, e.dx, e.y_pos, e.x_pos, e.time_ms, e.touch_id,
			e.port, e.kind};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_gesture(e);
	endtask

	task automatic rand_event(input bit tidy);
		kind_t k;
		logic [13:0] x, y;
		k = kind_t'($urandom_range(0, 3));
		now_ms = now_ms + (tidy ? $urandom_range(0, 120) : $urandom);
		if (tidy) begin
			x = 14'($urandom_range(0, MaxX)); y = 14'($urandom_range(0, MaxY));
		end else begin
			x = 14'($urandom); y = 14'($urandom);
		end
		send_event(k, 1'($urandom_range(0, 1)), tidy ? 8'($urandom_range(0, 4)) : 8'($urandom),
			now_ms, x, y, 15'($signed($urandom_range(0, 30720)) - 15360),
			15'($signed($urandom_range(0, 17408)) - 8704));
	endtask

	always @(posedge clk) begin
		res_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.pointer_x = m_axis_tdata[15:0];
			got.pointer_y = m_axis_tdata[31:16];
			got.button_left = m_axis_tdata[32];
			got.button_right = m_axis_tdata[33];
			if (pending_res.size() == 0) begin
				$error("unexpected item: %h", m_axis_tdata);
				errors++;
			end else begin
				want = pending_res.pop_front();
				n_results++;
				if (got.pointer_x !== want.pointer_x) begin
					$error("pointer_x exp %0d got %0d", want.pointer_x, got.pointer_x); errors++;
				end
				if (got.pointer_y !== want.pointer_y) begin
					$error("pointer_y exp %0d got %0d", want.pointer_y, got.pointer_y); errors++;
				end
				if (got.button_left !== want.button_left) begin
					$error("button_left exp %0b got %0b", want.button_left, got.button_left);
					errors++;
				end
				if (got.button_right !== want.button_right) begin
					$error("button_right exp %0b got %0b", want.button_right, got.button_right);
					errors++;
				end
			end
		end
	end

	initial begin
		m_axis_tready = 0;
		forever begin
			@(posedge clk);
			if (rx_hold) m_axis_tready <= 0;
			else if (!no_idle && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				m_axis_tready <= 1;
			end else m_axis_tready <= 1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rx_hold)
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic test_taps();
		send_event(KIND_DOWN, 0, 8'd1, 32'd100, 14'd1600, 14'd1600, 0, 0);
		send_event(KIND_UP, 0, 8'd1, 32'd200, 14'd1610, 14'd1600, 0, 0);
		send_event(KIND_TICK, 0, 8'd0, 32'd220, 0, 0, 0, 0);
		send_event(KIND_TICK, 0, 8'd0, 32'd260, 0, 0, 0, 0);
		send_event(KIND_DOWN, 1, 8'd5, 32'd300, 14'd100, 14'd100, 0, 0);
		send_event(KIND_DOWN, 1, 8'd6, 32'd310, 14'd200, 14'd200, 0, 0);
		send_event(KIND_UP, 1, 8'd6, 32'd400, 14'd200, 14'd200, 0, 0);
		send_event(KIND_UP, 1, 8'd5, 32'd410, 14'd100, 14'd100, 0, 0);
		send_event(KIND_TICK, 1, 8'd0, 32'd500, 0, 0, 0, 0);
		send_event(KIND_DOWN, 0, 8'd9, 32'd0, 14'h3fff, 14'h3fff, 0, 0);
		send_event(KIND_UP, 0, 8'd9, 32'd10, 14'h3fff, 14'h3fff, 0, 0);
		send_event(KIND_TICK, 0, 8'd0, 32'd900, 0, 0, 0, 0);
		send_event(KIND_UP, 0, 8'd77, 32'd950, 0, 0, 0, 0);
	endtask

	task automatic test_drags();
		now_ms = 1000;
		for (int p = 0; p < 2; p++) begin
			for (int f = 0; f < 3; f++)
				send_event(KIND_DOWN, 1'(p), 8'(10+f), now_ms + f, 14'd4000, 14'd4000, 0, 0);
			send_event(KIND_DOWN, 1'(p), 8'd10, now_ms + 5, 14'd4000, 14'd4000, 0, 0);
			send_event(KIND_DOWN, 1'(p), 8'd20, now_ms + 6, 14'd4000, 14'd4000, 0, 0);
			send_event(KIND_MOTION, 1'(p), 8'd11, now_ms + 600, 14'd5000, 14'd3000,
				15'sd15360, -15'sd8704);
			send_event(KIND_MOTION, 1'(p), 8'd99, now_ms + 610, 14'd0, 14'd0,
				-15'sd15360, 15'sd8704);
			for (int f = 0; f < 3; f++)
				send_event(KIND_UP, 1'(p), 8'(10+f), now_ms + 700, 0, 0, 0, 0);
			now_ms = now_ms + 1000;
		end
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++) rand_event($urandom_range(0, 9) != 0);
	endtask

	task automatic test_backpressure();
		fork
			begin
				rx_hold = 1;
				repeat (300) @(posedge clk);
				rx_hold = 0;
			end
			test_random(20);
		join
		wait_drained();
	endtask

	initial begin
		errors = 0; n_results = 0; idle_cycles = 0; rx_hold = 0; no_idle = 0;
		now_ms = 1;
		arst_n = 0; cfg_we = 0; cfg_addr = 0; cfg_wdata = 0;
		s_axis_tvalid = 0; s_axis_tdata = 0;
		mirror_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_taps();
		test_drags();
		test_random(150);
		write_reg(REG_INDIRECT, 16'd1);
		write_reg(REG_SPEED, 16'hffff);
		write_reg(REG_ORG_X, 16'h1fff);
		write_reg(REG_ORG_Y, 16'h2000);
		write_reg(REG_INV_X, 16'hffff);
		write_reg(REG_INV_Y, 16'd0);
		test_drags();
		test_random(150);
		test_backpressure();
		write_reg(REG_INDIRECT, 16'd0);
		write_reg(REG_SPEED, 16'd0);
		write_reg(REG_ORG_X, 16'h2000);
		write_reg(REG_ORG_Y, 16'h1fff);
		write_reg(REG_INV_X, 16'd0);
		write_reg(REG_INV_Y, 16'hffff);
		test_random(120);
		write_reg(REG_INDIRECT, 16'd1);
		write_reg(REG_SPEED, 16'd300);
		write_reg(REG_ORG_X, 16'd0);
		write_reg(REG_INV_X, 16'd5000);
		write_reg(REG_INV_Y, 16'd3000);
		test_random(120);
		no_idle = 1;
		test_random(60);
		wait_drained();
		$display("covered taps, drags, ticks, malformed items, six register settings, stall");
		$display("%0d results checked, %0d mismatches", n_results, errors);
		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule

// File: touch_gesture_to_mouse.f
hw/rtl/tgm_pkg.sv
hw/rtl/tgm_front.sv
hw/rtl/tgm_back.sv
hw/rtl/touch_gesture_to_mouse.sv
tb/touch_gesture_to_mouse_test.sv
